// ===== rtl/l2tsw_pkg.sv =====
package l2tsw_pkg;

	// Defaults for the top level parameters
	localparam int MAX_DIM_DEF          = 1024;
	localparam int MIN_PADDED_WIDTH_DEF = 64;

	// Fixed field widths
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W    = 32;
	localparam int OFF_W    = 22;

	// Tile geometry: 8x8 tiles, 64 pixels each
	localparam int TILE_SHIFT        = 3;
	localparam int TILE_PIXELS_SHIFT = 6;

	// Reset values of the registers
	localparam logic [CFG_W-1:0] IMAGE_DIM_RST = CFG_W'(64);

	// Register indexes on the write port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_PIXEL_FORMAT  = 2'd2,
		REG_REVERSE_BYTES = 2'd3
	} cfg_reg_t;

	// Pixel format codes
	localparam logic FMT_RGBA8    = 1'b0;
	localparam logic FMT_RGBA5551 = 1'b1;

	// Mode bits handed from the front to the back
	typedef struct packed {
		logic fmt;      // FMT_RGBA8 or FMT_RGBA5551
		logic reverse;  // byte reversal of 32-bit pixels
	} mode_t;

	// Z-order interleave of the low three column and row bits
	function automatic logic [TILE_PIXELS_SHIFT-1:0] morton_in_tile(
		input logic [TILE_SHIFT-1:0] x,
		input logic [TILE_SHIFT-1:0] y
	);
		morton_in_tile = {y[2], x[2], y[1], x[1], y[0], x[0]};
	endfunction

endpackage

// ===== rtl/l2tsw_fifo.sv =====
module l2tsw_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output logic [W-1:0] head_data
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	// Storage, no reset needed on payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/l2tsw_front.sv =====
module l2tsw_front #(
	parameter int MAX_DIM          = l2tsw_pkg::MAX_DIM_DEF,
	parameter int MIN_PADDED_WIDTH = l2tsw_pkg::MIN_PADDED_WIDTH_DEF,
	localparam int CW     = $clog2(MAX_DIM),
	localparam int PW_MAX = (MIN_PADDED_WIDTH > 2 * MAX_DIM) ? MIN_PADDED_WIDTH : 2 * MAX_DIM,
	localparam int PW_W   = $clog2(PW_MAX + 1),
	localparam int TW     = PW_W - l2tsw_pkg::TILE_SHIFT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// register write port
	input  logic                             cfg_we,
	input  logic [l2tsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [l2tsw_pkg::CFG_W-1:0]      cfg_data,
	// request in
	input  logic                             in_valid,
	input  logic                             q_full,
	output logic                             push,
	output logic [CW-1:0]                    x,
	output logic [CW-1:0]                    y,
	output logic                             last,
	// settings seen by the back
	output logic [TW-1:0]                    tiles_per_row,
	output l2tsw_pkg::mode_t                 mode
);

	localparam int CFG_W = l2tsw_pkg::CFG_W;
	localparam int DW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             fmt_q;
	logic             reverse_q;
	logic [CW-1:0]    col_q;
	logic [CW-1:0]    row_q;
	logic [TW-1:0]    tpr_q;

	logic [DW-1:0]    w_c;
	logic [DW-1:0]    h_c;
	logic [DW-1:0]    col_inc;
	logic [DW-1:0]    row_inc;
	logic [PW_W-1:0]  pw;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= l2tsw_pkg::IMAGE_DIM_RST;
			height_q  <= l2tsw_pkg::IMAGE_DIM_RST;
			fmt_q     <= l2tsw_pkg::FMT_RGBA8;
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			case (l2tsw_pkg::cfg_reg_t'(cfg_index))
				l2tsw_pkg::REG_IMAGE_WIDTH:   width_q   <= cfg_data;
				l2tsw_pkg::REG_IMAGE_HEIGHT:  height_q  <= cfg_data;
				l2tsw_pkg::REG_PIXEL_FORMAT:  fmt_q     <= cfg_data[0];
				l2tsw_pkg::REG_REVERSE_BYTES: reverse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp dimensions to 1..MAX_DIM
	always_comb begin
		if (width_q == '0) begin
			w_c = DW'(1);
		end else if (DW'(width_q) > DW'(MAX_DIM)) begin
			w_c = DW'(MAX_DIM);
		end else begin
			w_c = DW'(width_q);
		end
		if (height_q == '0) begin
			h_c = DW'(1);
		end else if (DW'(height_q) > DW'(MAX_DIM)) begin
			h_c = DW'(MAX_DIM);
		end else begin
			h_c = DW'(height_q);
		end
	end

	// Padded width: smallest MIN_PADDED_WIDTH << k that covers the width
	always_comb begin
		pw = PW_W'(MIN_PADDED_WIDTH);
		for (int k = CW; k >= 0; k--) begin
			if ((64'(MIN_PADDED_WIDTH) << k) >= 64'(w_c)) begin
				pw = PW_W'(64'(MIN_PADDED_WIDTH) << k);
			end
		end
	end

	// Tiles per row, registered from the padded width, so it trails a width write by one register
	always_ff @(posedge clk) begin
		tpr_q <= pw[PW_W-1:l2tsw_pkg::TILE_SHIFT];
	end

	// Raster position and end of row / image
	assign col_inc = DW'(col_q) + DW'(1);
	assign row_inc = DW'(row_q) + DW'(1);
	assign last    = (col_inc >= w_c) && (row_inc >= h_c);
	assign push    = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (col_inc >= w_c) begin
				col_q <= '0;
				if (row_inc >= h_c) begin
					row_q <= '0;
				end else begin
					row_q <= CW'(row_inc);
				end
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	assign x             = col_q;
	assign y             = row_q;
	assign tiles_per_row = tpr_q;
	assign mode.fmt      = fmt_q;
	assign mode.reverse  = reverse_q;

endmodule

// ===== rtl/l2tsw_back.sv =====
module l2tsw_back #(
	parameter int MAX_DIM          = l2tsw_pkg::MAX_DIM_DEF,
	parameter int MIN_PADDED_WIDTH = l2tsw_pkg::MIN_PADDED_WIDTH_DEF,
	localparam int CW     = $clog2(MAX_DIM),
	localparam int PW_MAX = (MIN_PADDED_WIDTH > 2 * MAX_DIM) ? MIN_PADDED_WIDTH : 2 * MAX_DIM,
	localparam int PW_W   = $clog2(PW_MAX + 1),
	localparam int TW     = PW_W - l2tsw_pkg::TILE_SHIFT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// queue head
	input  logic                          head_valid,
	input  logic [CW-1:0]                 x,
	input  logic [CW-1:0]                 y,
	input  logic                          last,
	input  logic [l2tsw_pkg::PIX_W-1:0]   pixel,
	output logic                          pop,
	// settings
	input  logic [TW-1:0]                 tiles_per_row,
	input  l2tsw_pkg::mode_t              mode,
	// result out
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [l2tsw_pkg::OFF_W-1:0]   dest_offset,
	output logic [l2tsw_pkg::PIX_W-1:0]   pixel_out,
	output logic                          last_pixel
);

	localparam int TS  = l2tsw_pkg::TILE_SHIFT;
	localparam int TPS = l2tsw_pkg::TILE_PIXELS_SHIFT;
	localparam int YTW = CW - TS;
	localparam int PRW = YTW + TW;
	localparam int IW  = PRW + TPS + 1;
	localparam int OW  = IW + 2;

	logic                         valid_q;
	logic [l2tsw_pkg::OFF_W-1:0]  offset_q;
	logic [l2tsw_pkg::PIX_W-1:0]  pixel_q;
	logic                         last_q;

	logic [PRW-1:0]               tile_row_base;
	logic [IW-1:0]                index;
	logic [OW-1:0]                offset;
	logic [l2tsw_pkg::PIX_W-1:0]  pixel_conv;
	logic                         load;

	// Linear pixel index: tile number times 64 plus the Z-order index
	always_comb begin
		tile_row_base = PRW'(y[CW-1:TS]) * PRW'(tiles_per_row);
		index = IW'({tile_row_base, TPS'(0)}) + IW'({x[CW-1:TS], TPS'(0)})
			+ IW'(l2tsw_pkg::morton_in_tile(x[TS-1:0], y[TS-1:0]));
		if (mode.fmt == l2tsw_pkg::FMT_RGBA5551) begin
			offset = OW'({index, 1'b0});
		end else begin
			offset = {index, 2'b00};
		end
	end

	// Pixel: low half in 16-bit format, optional byte reversal otherwise
	always_comb begin
		if (mode.fmt == l2tsw_pkg::FMT_RGBA5551) begin
			pixel_conv = {16'h0000, pixel[15:0]};
		end else if (mode.reverse) begin
			pixel_conv = {pixel[7:0], pixel[15:8], pixel[23:16], pixel[31:24]};
		end else begin
			pixel_conv = pixel;
		end
	end

	// Output register takes a new result when empty or being drained
	assign load = !valid_q || !out_stall;
	assign pop  = head_valid && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			offset_q <= l2tsw_pkg::OFF_W'(offset);
			pixel_q  <= pixel_conv;
			last_q   <= last;
		end
	end

	assign out_valid   = valid_q;
	assign dest_offset = offset_q;
	assign pixel_out   = pixel_q;
	assign last_pixel  = last_q;

endmodule

// ===== rtl/linear_to_tiled_texture_swizzle.sv =====
// Linear-to-tiled texture swizzle with 8x8 Z-order tiles.
// Input channel (in_valid / in_stall / pixel_in): source pixels in raster
// order. Output channel (out_valid / out_stall): for each pixel its byte
// offset in the tiled texture, the pixel to store and a flag on the final
// pixel of the image. Column and row counters wrap after that pixel.
// Register port (cfg_we / cfg_index / cfg_data): image width, image height,
// pixel format, byte reversal; write only while no request is in flight.
// An accepted request is written into the request queue and from there
// into the output register. Throughput: one pixel per cycle while the output
// is not stalled, set by the combinational address path (one multiply and add)
// between the request queue and the output register. A two-entry queue parts the counting front from
// the address back; in_stall rises only when that queue is full, so a stalled
// output lets two more requests in before the input stalls. Results hold
// while out_stall is high. Reset clears both counters, the queue and the
// output valid, and sets the registers to 64 x 64, RGBA8, no reversal.
module linear_to_tiled_texture_swizzle #(
	parameter int MAX_DIM          = l2tsw_pkg::MAX_DIM_DEF,
	parameter int MIN_PADDED_WIDTH = l2tsw_pkg::MIN_PADDED_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [l2tsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [l2tsw_pkg::CFG_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [l2tsw_pkg::PIX_W-1:0]      pixel_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [l2tsw_pkg::OFF_W-1:0]      dest_offset,
	output logic [l2tsw_pkg::PIX_W-1:0]      pixel_out,
	output logic                             last_pixel
);

	localparam int CW     = $clog2(MAX_DIM);
	localparam int PW_MAX = (MIN_PADDED_WIDTH > 2 * MAX_DIM) ? MIN_PADDED_WIDTH : 2 * MAX_DIM;
	localparam int PW_W   = $clog2(PW_MAX + 1);
	localparam int TW     = PW_W - l2tsw_pkg::TILE_SHIFT;
	localparam int PIX_W  = l2tsw_pkg::PIX_W;
	localparam int EW     = 1 + 2 * CW + PIX_W;

	logic                  push;
	logic                  q_full;
	logic [CW-1:0]         fx;
	logic [CW-1:0]         fy;
	logic                  flast;
	logic [TW-1:0]         tiles_per_row;
	l2tsw_pkg::mode_t      mode;
	logic                  head_valid;
	logic [EW-1:0]         head_data;
	logic                  pop;

	// Front: registers, counters, end-of-image detection
	l2tsw_front #(
		.MAX_DIM          (MAX_DIM),
		.MIN_PADDED_WIDTH (MIN_PADDED_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.q_full        (q_full),
		.push          (push),
		.x             (fx),
		.y             (fy),
		.last          (flast),
		.tiles_per_row (tiles_per_row),
		.mode          (mode)
	);

	// Request queue between front and back
	l2tsw_fifo #(
		.W (EW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({flast, fy, fx, pixel_in}),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Back: address, pixel conversion, output register
	l2tsw_back #(
		.MAX_DIM          (MAX_DIM),
		.MIN_PADDED_WIDTH (MIN_PADDED_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.x             (head_data[PIX_W +: CW]),
		.y             (head_data[PIX_W + CW +: CW]),
		.last          (head_data[EW-1]),
		.pixel         (head_data[PIX_W-1:0]),
		.pop           (pop),
		.tiles_per_row (tiles_per_row),
		.mode          (mode),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.dest_offset   (dest_offset),
		.pixel_out     (pixel_out),
		.last_pixel    (last_pixel)
	);

	assign in_stall = q_full;

endmodule

// ===== rtl/l2tsw_checker.sv =====
module l2tsw_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [l2tsw_pkg::OFF_W-1:0]      dest_offset,
	input logic [l2tsw_pkg::PIX_W-1:0]      pixel_out,
	input logic                             last_pixel
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] inflight_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// No result without a request behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result shown with no request in flight");

	// Queue plus output register bound the requests in flight
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more requests in flight than storage allows");

	// Offsets are always at least 2-byte aligned
	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !dest_offset[0])
		else $error("odd destination offset");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(dest_offset)
			&& $stable(pixel_out) && $stable(last_pixel))
		else $error("stalled result changed");

endmodule

bind linear_to_tiled_texture_swizzle l2tsw_checker u_l2tsw_checker (.*);
